// File: sv/xte_pkg.sv
// ----------------------------------------------------------------------------
// xte_pkg
// Shared types, constants and the run spelling function of the XML text
// escape encoder.
// ----------------------------------------------------------------------------
package xte_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [2:0] {
        K_PASS = 3'd0,
        K_LT   = 3'd1,
        K_GT   = 3'd2,
        K_AMP  = 3'd3,
        K_APOS = 3'd4,
        K_QUOT = 3'd5,
        K_NUM  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        logic [3:0]  hun;
        logic [3:0]  ten;
        logic [3:0]  one;
        logic [1:0]  ndig;
    } t_desc;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_run_char;

    function automatic logic [7:0] digit_char(logic [3:0] d);
        return CH_ZERO | {4'h0, d};
    endfunction

    function automatic t_run_char run_char(t_desc d, logic [2:0] pos);
        logic [47:0] s;
        logic [2:0]  len;
        t_run_char   r;
        s   = '0;
        len = 3'd1;
        case (d.kind)
            K_LT: begin
                s   = {"&lt;", 16'h0};
                len = 3'd4;
            end
            K_GT: begin
                s   = {"&gt;", 16'h0};
                len = 3'd4;
            end
            K_AMP: begin
                s   = {"&amp;", 8'h0};
                len = 3'd5;
            end
            K_APOS: begin
                s   = "&apos;";
                len = 3'd6;
            end
            K_QUOT: begin
                s   = "&quot;";
                len = 3'd6;
            end
            K_NUM: begin
                case (d.ndig)
                    2'd3: s = {CH_AMP, CH_HASH, digit_char(d.hun), digit_char(d.ten),
                               digit_char(d.one), CH_SEMI};
                    2'd2: s = {CH_AMP, CH_HASH, digit_char(d.ten), digit_char(d.one),
                               CH_SEMI, 8'h0};
                    default: s = {CH_AMP, CH_HASH, digit_char(d.one), CH_SEMI, 16'h0};
                endcase
                len = {1'b0, d.ndig} + 3'd3;
            end
            default: begin
                s   = {d.code, 40'h0};
                len = 3'd1;
            end
        endcase
        r.ch   = s[47 - 8 * pos -: 8];
        r.last = (pos == len - 3'd1);
        return r;
    endfunction

endpackage

// File: sv/xml_text_escape_encoder.sv
// ----------------------------------------------------------------------------
// xml_text_escape_encoder
// Escapes a byte stream for XML text: reserved characters become entity
// names, bytes 0-8, 14-31 and 127-255 become decimal references.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       sink       i_in_valid / o_in_stall   i_in_byte
// out      source     o_out_valid / i_out_stall o_out_byte, o_run_last
//
// Each input byte yields a run of one to six output beats, one beat a cycle
// while i_out_stall is low, so a pass-through byte yields one beat and an
// escaped byte four to six. The run sequencer in the back end sets the rate; a
// four-entry queue lets the input keep accepting while a run is being sent.
// Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module xml_text_escape_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import xte_pkg::*;

    t_desc push_desc;
    t_desc head;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;

    xte_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    xte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    xte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

// File: sv/xte_front.sv
// ----------------------------------------------------------------------------
// xte_front
// Accepts input beats, classifies each byte and splits it into decimal digits.
// ----------------------------------------------------------------------------
module xte_front (
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_full,
    output logic          o_in_stall,
    output logic          o_push,
    output xte_pkg::t_desc o_desc
);
    import xte_pkg::*;

    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;

    always_comb begin
        o_desc.code = i_in_byte;
        case (i_in_byte) inside
            CH_LT:   o_desc.kind = K_LT;
            CH_GT:   o_desc.kind = K_GT;
            CH_AMP:  o_desc.kind = K_AMP;
            CH_APOS: o_desc.kind = K_APOS;
            CH_QUOT: o_desc.kind = K_QUOT;
            [8'd0:8'd8], [8'd14:8'd31], [8'd127:8'd255]: o_desc.kind = K_NUM;
            default: o_desc.kind = K_PASS;
        endcase

        if (i_in_byte >= 8'd200) begin
            o_desc.hun = 4'd2;
            rem        = 7'(i_in_byte - 8'd200);
        end else if (i_in_byte >= 8'd100) begin
            o_desc.hun = 4'd1;
            rem        = 7'(i_in_byte - 8'd100);
        end else begin
            o_desc.hun = 4'd0;
            rem        = i_in_byte[6:0];
        end
        prod        = 15'(rem) * 15'd205;
        ten         = prod[14:11];
        o_desc.ten  = ten;
        o_desc.one  = 4'(rem - 7'(ten) * 7'd10);
        o_desc.ndig = (i_in_byte >= 8'd100) ? 2'd3 : (i_in_byte >= 8'd10) ? 2'd2 : 2'd1;
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

// File: sv/xte_queue.sv
// ----------------------------------------------------------------------------
// xte_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module xte_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xte_pkg::t_desc i_desc,
    input  logic           i_pop,
    output xte_pkg::t_desc o_head,
    output logic           o_empty,
    output logic           o_full
);
    import xte_pkg::*;

    t_desc          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

// File: sv/xte_back.sv
// ----------------------------------------------------------------------------
// xte_back
// Walks the run of each queued byte and drives the output register.
// ----------------------------------------------------------------------------
module xte_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xte_pkg::t_desc i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);
    import xte_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic       load;
    t_run_char  rc;

    assign load = !r_valid || !i_out_stall;
    assign rc   = run_char(i_head, r_pos);
    assign o_pop = load && !i_empty && rc.last;

    always_comb begin
        n_pos = r_pos;
        if (load && !i_empty) begin
            n_pos = rc.last ? 3'd0 : r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            r_pos <= n_pos;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= rc.ch;
            r_last <= rc.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_run_last  = r_last;

endmodule

// File: sv/xte_checker.sv
// ----------------------------------------------------------------------------
// xte_checker
// Port-level checks of the XML text escape encoder.
// ----------------------------------------------------------------------------
module xte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);
    import xte_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("Stalled output beat changed.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Encoder not empty after reset.");

    a_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_byte != CH_LT && o_out_byte != CH_GT
            && o_out_byte != CH_QUOT && o_out_byte != CH_APOS)
        else $error("Reserved character sent unescaped.");

    a_amp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_last |-> o_out_byte != CH_AMP)
        else $error("Run ended on an ampersand.");

endmodule

bind xml_text_escape_encoder xte_checker u_xte_checker (.*);
